FILE: hdl/trc_pkg.sv
// Shared types, codes and constants for the thermostat relay controller.
`default_nettype none

package trc_pkg;

    // Default depth of the learned rate table
    localparam int RATE_TABLE_DEPTH_DEF = 64;

    // Floor sensor valid window and learning limits
    localparam logic [11:0] ADC_HIGH_BAD = 12'd3500;
    localparam logic [11:0] ADC_LOW_BAD  = 12'd20;
    localparam logic [15:0] RATE_SLACK   = 16'd5;
    localparam logic [15:0] RATE_CAP     = 16'd60;
    localparam logic [15:0] MINUTES_MAX  = 16'hFFFF;

    // Offset of the air correction register and of the rate table index
    localparam logic signed [9:0] CORR_ZERO  = 10'sd5;
    localparam logic signed [8:0] INDEX_BASE = 9'sd5;

    // Heat modes
    localparam logic [1:0] MODE_MANUAL     = 2'd0;
    localparam logic [1:0] MODE_PROGRAM    = 2'd1;
    localparam logic [1:0] MODE_ANTIFREEZE = 2'd2;

    // Sensor selections
    localparam logic [1:0] SENS_NONE  = 2'd0;
    localparam logic [1:0] SENS_AIR   = 2'd1;
    localparam logic [1:0] SENS_FLOOR = 2'd2;
    localparam logic [1:0] SENS_BOTH  = 2'd3;

    // Input actions
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Schedule event marker after reset
    localparam logic [2:0] NO_EVENT = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_OP_MODE          = 3'd0;
    localparam logic [2:0] REG_SENSOR_SEL       = 3'd1;
    localparam logic [2:0] REG_AIR_CORRECTION   = 3'd2;
    localparam logic [2:0] REG_AIR_SETPOINT     = 3'd3;
    localparam logic [2:0] REG_MANUAL_LIMIT     = 3'd4;
    localparam logic [2:0] REG_ANTIFREEZE_LIMIT = 3'd5;

    typedef struct packed {
        logic [1:0] op_mode;
        logic [1:0] sensor_sel;
        logic [3:0] air_correction;
        logic [6:0] air_setpoint;
        logic [6:0] manual_floor_limit;
        logic [6:0] antifreeze_floor_limit;
    } cfg_t;

    typedef struct packed {
        logic              action;
        logic signed [7:0] air_temp;
        logic signed [7:0] floor_temp;
        logic [11:0]       floor_adc;
        logic [1:0]        event_index;
        logic [6:0]        event_target;
    } item_t;

    typedef struct packed {
        logic       heat_relay;
        logic       sensor_fault;
        logic [6:0] program_target;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic signed [8:0] idx;
        logic [15:0]       minutes;
    } learn_req_t;

endpackage

`default_nettype wire

FILE: hdl/trc_ctrl.sv
// Relay decision, sensor fault check and program target state for one beat.
`default_nettype none

module trc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire trc_pkg::item_t    item,
    input  wire trc_pkg::cfg_t     cfg,
    output trc_pkg::result_t       result,
    output trc_pkg::learn_req_t    learn_req
);
    import trc_pkg::*;

    logic              relay_reg, relay_next;
    logic              fault_reg, fault_next;
    logic [2:0]        last_event_reg, last_event_next;
    logic [6:0]        target_reg, target_next;
    logic signed [7:0] start_temp_reg, start_temp_next;
    logic [15:0]       minutes_reg, minutes_next;

    // Work out the state after the beat held in the input register
    always_comb
    begin
        logic signed [9:0] air;
        logic signed [9:0] floor_t;
        logic signed [9:0] limit;
        logic signed [9:0] setp;
        logic [6:0]        limit_u;
        logic              run;
        logic              prog;
        logic              on_ok;
        logic              off_ok;

        relay_next      = relay_reg;
        fault_next      = fault_reg;
        last_event_next = last_event_reg;
        target_next     = target_reg;
        start_temp_next = start_temp_reg;
        minutes_next    = minutes_reg;
        learn_req       = '0;
        limit_u         = '0;
        run             = 1'b0;
        prog            = 1'b0;
        on_ok           = 1'b0;

        air     = 10'(item.air_temp) + $signed({6'b0, cfg.air_correction}) - CORR_ZERO;
        floor_t = 10'(item.floor_temp);
        setp    = $signed({3'b0, cfg.air_setpoint});

        if (item.action == ACT_TICK)
        begin
            if (minutes_reg != MINUTES_MAX)
                minutes_next = minutes_reg + 16'd1;
        end
        else
        begin
            // Check the floor sensor window
            if (cfg.sensor_sel[1])
                fault_next = (item.floor_adc >= ADC_HIGH_BAD) ||
                             (item.floor_adc <= ADC_LOW_BAD);

            // Pick the floor limit by mode
            case (cfg.op_mode)
                MODE_MANUAL:
                begin
                    run     = 1'b1;
                    limit_u = cfg.manual_floor_limit;
                end
                MODE_ANTIFREEZE:
                begin
                    run     = 1'b1;
                    limit_u = cfg.antifreeze_floor_limit;
                end
                MODE_PROGRAM:
                begin
                    run  = 1'b1;
                    prog = 1'b1;
                    if (last_event_reg != {1'b0, item.event_index})
                    begin
                        last_event_next = {1'b0, item.event_index};
                        target_next     = item.event_target;
                    end
                    limit_u = target_next;
                end
                default:
                begin
                    run = 1'b0;
                end
            endcase
        end

        limit = $signed({3'b0, limit_u});

        // Switch-on condition by sensor selection
        case (cfg.sensor_sel)
            SENS_BOTH:  on_ok = (air < setp) && (floor_t < limit);
            SENS_FLOOR: on_ok = floor_t < limit;
            SENS_AIR:   on_ok = air < limit;
            default:    on_ok = 1'b0;
        endcase

        off_ok = (cfg.sensor_sel[1] && (floor_t > limit)) ||
                 ((cfg.sensor_sel == SENS_BOTH) && (air > setp)) ||
                 ((cfg.sensor_sel == SENS_AIR) && (air > limit));

        if (run)
        begin
            // Switch on first, then off on the updated state
            if (!fault_next && !relay_reg && on_ok)
            begin
                relay_next = 1'b1;
                if (prog)
                begin
                    minutes_next = '0;
                    if (cfg.sensor_sel[1])
                        start_temp_next = item.floor_temp;
                end
            end
            if (relay_next && off_ok)
                relay_next = 1'b0;

            // Close a learning interval once the floor has warmed
            if (prog && cfg.sensor_sel[1] && !fault_next && relay_next &&
                (minutes_next != '0) && (item.floor_temp > start_temp_next))
            begin
                learn_req.valid   = step;
                learn_req.idx     = 9'(start_temp_next) - INDEX_BASE;
                learn_req.minutes = minutes_next;
                start_temp_next   = item.floor_temp;
                minutes_next      = '0;
            end
        end

        result.heat_relay     = relay_next;
        result.sensor_fault   = fault_next;
        result.program_target = target_next;
    end

    // Advance the control state on each beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg      <= 1'b0;
            fault_reg      <= 1'b0;
            last_event_reg <= NO_EVENT;
            target_reg     <= '0;
            start_temp_reg <= '0;
            minutes_reg    <= '0;
        end
        else if (step)
        begin
            relay_reg      <= relay_next;
            fault_reg      <= fault_next;
            last_event_reg <= last_event_next;
            target_reg     <= target_next;
            start_temp_reg <= start_temp_next;
            minutes_reg    <= minutes_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/trc_learn.sv
// Rate table of learned minutes per degree with a read-modify-write pipeline.
`default_nettype none

module trc_learn #(
    parameter int RATE_TABLE_DEPTH = trc_pkg::RATE_TABLE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire trc_pkg::learn_req_t learn_req
);
    import trc_pkg::*;

    localparam int AW = $clog2(RATE_TABLE_DEPTH);

    logic [5:0]                  table_mem [RATE_TABLE_DEPTH];
    logic [RATE_TABLE_DEPTH-1:0] entry_valid_reg;
    logic [5:0]                  rd_data_reg;
    logic                        rd_hit_reg;
    logic                        pend_reg;
    logic [AW-1:0]               pend_addr_reg;
    logic [15:0]                 pend_min_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   cur_rate;
    logic [15:0]   diff;
    logic          wr_en;
    logic [5:0]    wr_data;
    logic          fwd;

    // Drop requests whose index falls outside the table
    always_comb
    begin
        rd_en   = learn_req.valid && !learn_req.idx[8] &&
                  (int'(learn_req.idx[7:0]) < RATE_TABLE_DEPTH);
        rd_addr = learn_req.idx[AW-1:0];
    end

    // Compare the stored rate with the new minutes and decide the write
    always_comb
    begin
        cur_rate = rd_hit_reg ? {10'b0, rd_data_reg} : 16'd0;
        diff     = (cur_rate > pend_min_reg) ? (cur_rate - pend_min_reg)
                                             : (pend_min_reg - cur_rate);
        wr_en    = pend_reg && (diff > RATE_SLACK);
        wr_data  = (pend_min_reg < RATE_CAP) ? pend_min_reg[5:0] : RATE_CAP[5:0];
        fwd      = wr_en && (pend_addr_reg == rd_addr);
    end

    // Table storage with registered read, forwarding a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[pend_addr_reg] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg   <= fwd ? wr_data : table_mem[rd_addr];
            pend_addr_reg <= rd_addr;
            pend_min_reg  <= learn_req.minutes;
        end
    end

    // Track written entries; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (rd_en)
                rd_hit_reg <= entry_valid_reg[rd_addr] || fwd;
            if (wr_en)
                entry_valid_reg[pend_addr_reg] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/thermostat_relay_control.sv
// Floor heating relay controller: input and result registers around the decision logic.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per measurement update
//   (action = 0: air and floor temperatures, floor converter word, schedule
//   event) or per one-minute tick (action = 1).
//   Result channel (out_valid/out_ready) returns one beat per input beat:
//   relay state, floor sensor fault flag and the latched program target.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle, while no beat is in flight.
// Timing:
//   out_valid rises when the beat moves from the input register into the result
//   register, which can wait while the result slot is held. One beat per cycle is
//   sustained while the receiver takes each result; the state update is
//   combinational between those two registers.
//   Learning writes go through a separate read-modify-write on the rate table
//   (registered read, then compare and write) and never hold up the channels.
// Reset and stalls:
//   Reset clears relay, fault and learning state, marks all rate table entries
//   unwritten at once so they read as zero, and loads the default configuration.
//   When the receiver stalls, the result holds and one more beat waits in the input register.
`default_nettype none

module thermostat_relay_control #(
    parameter int RATE_TABLE_DEPTH = trc_pkg::RATE_TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              action,
    input  wire logic signed [7:0] air_temp,
    input  wire logic signed [7:0] floor_temp,
    input  wire logic [11:0]       floor_adc,
    input  wire logic [1:0]        event_index,
    input  wire logic [6:0]        event_target,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   heat_relay,
    output logic                   sensor_fault,
    output logic [6:0]             program_target
);
    import trc_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    learn_req_t learn_req;
    logic       advance;

    // Move a beat forward when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode                <= MODE_MANUAL;
            cfg_reg.sensor_sel             <= SENS_BOTH;
            cfg_reg.air_correction         <= 4'd5;
            cfg_reg.air_setpoint           <= 7'd22;
            cfg_reg.manual_floor_limit     <= 7'd28;
            cfg_reg.antifreeze_floor_limit <= 7'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OP_MODE:          cfg_reg.op_mode                <= cfg_data[1:0];
                REG_SENSOR_SEL:       cfg_reg.sensor_sel             <= cfg_data[1:0];
                REG_AIR_CORRECTION:   cfg_reg.air_correction         <= cfg_data[3:0];
                REG_AIR_SETPOINT:     cfg_reg.air_setpoint           <= cfg_data;
                REG_MANUAL_LIMIT:     cfg_reg.manual_floor_limit     <= cfg_data;
                REG_ANTIFREEZE_LIMIT: cfg_reg.antifreeze_floor_limit <= cfg_data;
                default:              cfg_reg                        <= cfg_reg;
            endcase
        end
    end

    // Input register valid flag and result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the input beat and the result payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.action       <= action;
            item_reg.air_temp     <= air_temp;
            item_reg.floor_temp   <= floor_temp;
            item_reg.floor_adc    <= floor_adc;
            item_reg.event_index  <= event_index;
            item_reg.event_target <= event_target;
        end
        if (advance)
            result_reg <= result_next;
    end

    trc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .result    (result_next),
        .learn_req (learn_req)
    );

    trc_learn #(
        .RATE_TABLE_DEPTH (RATE_TABLE_DEPTH)
    ) u_learn (
        .clk       (clk),
        .rst_n     (rst_n),
        .learn_req (learn_req)
    );

    assign out_valid      = out_valid_reg;
    assign heat_relay     = result_reg.heat_relay;
    assign sensor_fault   = result_reg.sensor_fault;
    assign program_target = result_reg.program_target;

endmodule

`default_nettype wire
